[src/sphd_pkg.sv]
// ----------------------------------------------------------------------------
// Spectral peak hold package
// Shared widths, codes and record types of the spectral peak hold block.
// ----------------------------------------------------------------------------
package sphd_pkg;

  localparam int IDX_W      = 9;
  localparam int AMP_W      = 24;
  localparam int MAG_W      = 23;
  localparam int FREQ_W     = 32;
  localparam int GAIN_W     = 16;
  localparam int DECAY_W    = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [MAG_W-1:0]   MAG_MAX     = 23'h7F_FFFF;
  localparam logic [AMP_W-1:0]   AMP_MIN     = 24'h80_0000;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd1024;
  localparam logic [DECAY_W-1:0] DECAY_UNITY = 17'h1_0000;

  // Commands carried in the cmd field.
  localparam logic CMD_PROCESS = 1'b0;
  localparam logic CMD_CLEAR   = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY     = 2'd2;

  typedef enum logic [1:0] {
    MODE_HOLD_PAIR = 2'd0,
    MODE_HOLD_AMP  = 2'd1,
    MODE_INVERSE   = 2'd2,
    MODE_PASS      = 2'd3
  } hold_mode_e;

  typedef struct packed {
    hold_mode_e         hold_mode;
    logic [GAIN_W-1:0]  inv_gain;
    logic [DECAY_W-1:0] decay_factor;
  } cfg_t;

  // A classified input word, as the front hands it to the back.
  typedef struct packed {
    logic              clear;
    logic              in_range;
    logic [IDX_W-1:0]  bin_index;
    logic [MAG_W-1:0]  mag;
    logic [MAG_W-1:0]  mag_decayed;
    logic [AMP_W-1:0]  amp;
    logic [FREQ_W-1:0] freq;
  } item_t;

  typedef struct packed {
    logic [AMP_W-1:0]  amp;
    logic [FREQ_W-1:0] freq;
  } result_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

[src/sphd_fifo.sv]
// ----------------------------------------------------------------------------
// Spectral peak hold queue
// Small register queue that decouples two pipeline sections.
// ----------------------------------------------------------------------------
module sphd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign ready_o = (count_q != CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = store_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[src/sphd_front.sv]
// ----------------------------------------------------------------------------
// Spectral peak hold front
// Accepts input words, checks the bin range and precomputes the magnitude.
// ----------------------------------------------------------------------------
module sphd_front #(
  parameter int BIN_COUNT = 512
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic                         cmd_i,
  input  logic [sphd_pkg::IDX_W-1:0]   bin_index_i,
  input  logic [sphd_pkg::AMP_W-1:0]   amplitude_in_i,
  input  logic [sphd_pkg::FREQ_W-1:0]  frequency_in_i,
  input  sphd_pkg::cfg_t               cfg_i,
  input  sphd_pkg::back_status_t       status_i,
  output sphd_pkg::item_t              item_o,
  output logic                         item_valid_o,
  input  logic                         item_ready_i
);
  import sphd_pkg::*;

  logic                     valid_q, valid_d;
  item_t                    item_q, item_d;
  logic                     accept;
  logic [AMP_W-1:0]         neg_amp;
  logic [MAG_W-1:0]         mag;
  logic [MAG_W+GAIN_W-1:0]  mag_prod;

  assign full_o       = status_i.clearing || (valid_q && !item_ready_i);
  assign accept       = push_i && !full_o;
  assign item_o       = item_q;
  assign item_valid_o = valid_q;

  // The most negative amplitude has no positive twin and saturates.
  assign neg_amp  = AMP_W'(0) - amplitude_in_i;
  assign mag      = !amplitude_in_i[AMP_W-1] ? amplitude_in_i[MAG_W-1:0] :
                    (amplitude_in_i == AMP_MIN) ? MAG_MAX : neg_amp[MAG_W-1:0];
  assign mag_prod = mag * cfg_i.decay_factor[GAIN_W-1:0];

  always_comb begin
    item_d             = item_q;
    item_d.clear       = (cmd_i == CMD_CLEAR);
    item_d.in_range    = ({{(32 - IDX_W){1'b0}}, bin_index_i} < 32'(BIN_COUNT));
    item_d.bin_index   = bin_index_i;
    item_d.mag         = mag;
    item_d.mag_decayed = mag_prod[MAG_W+GAIN_W-1:GAIN_W];
    item_d.amp         = amplitude_in_i;
    item_d.freq        = frequency_in_i;
    valid_d            = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (item_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

[src/sphd_back.sv]
// ----------------------------------------------------------------------------
// Spectral peak hold back
// Reads the held entry, applies the hold mode and decay, writes it back.
// ----------------------------------------------------------------------------
module sphd_back #(
  parameter int MEM_DEPTH = 512
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sphd_pkg::item_t         item_i,
  input  logic                    item_valid_i,
  output logic                    item_ready_o,
  input  sphd_pkg::cfg_t          cfg_i,
  output sphd_pkg::back_status_t  status_o,
  output sphd_pkg::result_t       res_o,
  output logic                    res_valid_o,
  input  logic                    res_ready_i
);
  import sphd_pkg::*;

  localparam int AddrW = $clog2(MEM_DEPTH);

  logic [MAG_W-1:0]  amp_mem  [MEM_DEPTH];
  logic [FREQ_W-1:0] freq_mem [MEM_DEPTH];

  logic              clearing_q, clearing_d;
  logic [AddrW-1:0]  clr_addr_q, clr_addr_d;

  logic              s2_valid_q, s2_valid_d;
  item_t             s2_item_q;
  logic [MAG_W-1:0]  rd_amp_q, byp_amp_q;
  logic [FREQ_W-1:0] rd_freq_q, byp_freq_q;
  logic              byp_amp_hit_q, byp_freq_hit_q;

  logic              rd_en, s2_fire;
  logic [AddrW-1:0]  rd_addr, s2_addr;
  logic [MAG_W-1:0]  held;
  logic [FREQ_W-1:0] held_freq;
  logic [MAG_W+GAIN_W-1:0] gain_prod, decay_prod;
  logic [MAG_W+GAIN_W-9:0] gain_scaled;
  logic [MAG_W-1:0]  inv_amp;
  logic              decay_on, take_mag;
  logic              amp_we, freq_we;
  logic [MAG_W-1:0]  new_amp;
  logic [FREQ_W-1:0] new_freq;
  result_t           res;

  logic              amp_wr_en, freq_wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic [MAG_W-1:0]  amp_wr_data;
  logic [FREQ_W-1:0] freq_wr_data;

  assign status_o.clearing = clearing_q;
  assign s2_fire      = s2_valid_q && res_ready_i;
  assign item_ready_o = !clearing_q && (!s2_valid_q || s2_fire);
  assign rd_en        = item_valid_i && item_ready_o;
  assign rd_addr      = item_i.bin_index[AddrW-1:0];
  assign s2_addr      = s2_item_q.bin_index[AddrW-1:0];
  assign res_o        = res;
  assign res_valid_o  = s2_valid_q;

  // An entry written in the same cycle as it was read comes from the bypass.
  assign held      = byp_amp_hit_q ? byp_amp_q : rd_amp_q;
  assign held_freq = byp_freq_hit_q ? byp_freq_q : rd_freq_q;

  assign gain_prod   = held * cfg_i.inv_gain;
  assign gain_scaled = gain_prod[MAG_W+GAIN_W-1:8];
  assign inv_amp     = (|gain_scaled[MAG_W+GAIN_W-9:MAG_W]) ? MAG_MAX :
                       gain_scaled[MAG_W-1:0];
  assign decay_prod  = held * cfg_i.decay_factor[GAIN_W-1:0];
  assign decay_on    = !cfg_i.decay_factor[DECAY_W-1];

  always_comb begin
    res.amp  = s2_item_q.amp;
    res.freq = s2_item_q.freq;
    take_mag = 1'b0;
    amp_we   = 1'b0;
    freq_we  = 1'b0;
    new_amp  = held;
    new_freq = s2_item_q.freq;
    if (s2_item_q.clear) begin
      res.amp  = '0;
      res.freq = '0;
      if (s2_item_q.in_range) begin
        amp_we   = 1'b1;
        freq_we  = 1'b1;
        new_amp  = '0;
        new_freq = '0;
      end
    end else if (s2_item_q.in_range) begin
      case (cfg_i.hold_mode)
        MODE_HOLD_PAIR: begin
          if (s2_item_q.mag < held) begin
            res.amp  = {1'b0, held};
            res.freq = held_freq;
          end else begin
            take_mag = 1'b1;
            freq_we  = 1'b1;
          end
        end
        MODE_HOLD_AMP: begin
          if (s2_item_q.mag < held) begin
            res.amp = {1'b0, held};
          end else begin
            take_mag = 1'b1;
          end
        end
        MODE_INVERSE: begin
          if (s2_item_q.mag > held) begin
            res.amp  = {1'b0, inv_amp};
            res.freq = held_freq;
          end else begin
            take_mag = 1'b1;
            freq_we  = 1'b1;
          end
        end
        default: begin
        end
      endcase
      // Decay acts on the value the mode step leaves behind.
      if (decay_on) begin
        amp_we  = 1'b1;
        new_amp = take_mag ? s2_item_q.mag_decayed :
                  decay_prod[MAG_W+GAIN_W-1:GAIN_W];
      end else begin
        amp_we  = take_mag;
        new_amp = s2_item_q.mag;
      end
    end
  end

  assign amp_wr_en    = clearing_q || (s2_fire && amp_we);
  assign freq_wr_en   = clearing_q || (s2_fire && freq_we);
  assign wr_addr      = clearing_q ? clr_addr_q : s2_addr;
  assign amp_wr_data  = clearing_q ? '0 : new_amp;
  assign freq_wr_data = clearing_q ? '0 : new_freq;

  always_comb begin
    clearing_d = clearing_q;
    clr_addr_d = clr_addr_q;
    if (clearing_q) begin
      if (clr_addr_q == AddrW'(MEM_DEPTH - 1)) begin
        clearing_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + 1'b1;
      end
    end
    s2_valid_d = s2_valid_q;
    if (rd_en) begin
      s2_valid_d = 1'b1;
    end else if (s2_fire) begin
      s2_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      clearing_q <= clearing_d;
      clr_addr_q <= clr_addr_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s2_item_q      <= item_i;
      byp_amp_hit_q  <= amp_wr_en && (wr_addr == rd_addr);
      byp_freq_hit_q <= freq_wr_en && (wr_addr == rd_addr);
      byp_amp_q      <= amp_wr_data;
      byp_freq_q     <= freq_wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (amp_wr_en) begin
      amp_mem[wr_addr] <= amp_wr_data;
    end
    if (rd_en) begin
      rd_amp_q <= amp_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (freq_wr_en) begin
      freq_mem[wr_addr] <= freq_wr_data;
    end
    if (rd_en) begin
      rd_freq_q <= freq_mem[rd_addr];
    end
  end

endmodule

[src/spectral_peak_hold_decay.sv]
// ----------------------------------------------------------------------------
// Spectral peak hold with decay
// Per-bin peak hold of amplitude and frequency with gain and persistence.
//
//   Channel   Handshake                 Words
//   input     push / full               cmd, bin_index, amplitude_in, frequency_in
//   result    empty / pop               amplitude_out, frequency_out
//   config    cfg_valid_i / cfg_ready_o register index and data
//
// One word per cycle is accepted unless full, one result per cycle when popped.
// Each word passes the front register, item queue, back stage and result queue.
// The rate is set by one read and one write of the held entry per cycle,
// with a bypass for back-to-back words on the same bin.
// After reset the min(BIN_COUNT, 512) store entries are cleared with full high.
// A stalled result queue fills the pipeline and then raises full.
// ----------------------------------------------------------------------------
module spectral_peak_hold_decay #(
  parameter int BIN_COUNT = 512
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic                              cmd_i,
  input  logic [sphd_pkg::IDX_W-1:0]        bin_index_i,
  input  logic signed [sphd_pkg::AMP_W-1:0] amplitude_in_i,
  input  logic signed [sphd_pkg::FREQ_W-1:0] frequency_in_i,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [sphd_pkg::AMP_W-1:0] amplitude_out_o,
  output logic signed [sphd_pkg::FREQ_W-1:0] frequency_out_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sphd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sphd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import sphd_pkg::*;

  localparam int MemDepth = (BIN_COUNT < (1 << IDX_W)) ? BIN_COUNT : (1 << IDX_W);

  hold_mode_e         hold_mode_q;
  logic [GAIN_W-1:0]  inv_gain_q;
  logic [DECAY_W-1:0] decay_factor_q;
  cfg_t               cfg;

  item_t        front_item, queue_item;
  logic         front_valid, queue_ready, queue_valid, back_ready;
  back_status_t back_status;
  result_t      back_res, out_res;
  logic         back_res_valid, out_ready, out_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_mode_q    <= MODE_HOLD_PAIR;
      inv_gain_q     <= GAIN_RESET;
      decay_factor_q <= DECAY_UNITY;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_HOLD_MODE: hold_mode_q    <= hold_mode_e'(cfg_data_i[1:0]);
        CFG_INV_GAIN:  inv_gain_q     <= cfg_data_i[GAIN_W-1:0];
        CFG_DECAY:     decay_factor_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign cfg.hold_mode    = hold_mode_q;
  assign cfg.inv_gain     = inv_gain_q;
  assign cfg.decay_factor = decay_factor_q;

  sphd_front #(
    .BIN_COUNT(BIN_COUNT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .cmd_i         (cmd_i),
    .bin_index_i   (bin_index_i),
    .amplitude_in_i(amplitude_in_i),
    .frequency_in_i(frequency_in_i),
    .cfg_i         (cfg),
    .status_i      (back_status),
    .item_o        (front_item),
    .item_valid_o  (front_valid),
    .item_ready_i  (queue_ready)
  );

  sphd_fifo #(
    .WIDTH($bits(item_t)),
    .DEPTH(2)
  ) u_item_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_valid),
    .data_i (front_item),
    .ready_o(queue_ready),
    .pop_i  (back_ready),
    .valid_o(queue_valid),
    .data_o (queue_item)
  );

  sphd_back #(
    .MEM_DEPTH(MemDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (queue_item),
    .item_valid_i(queue_valid),
    .item_ready_o(back_ready),
    .cfg_i       (cfg),
    .status_o    (back_status),
    .res_o       (back_res),
    .res_valid_o (back_res_valid),
    .res_ready_i (out_ready)
  );

  sphd_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(2)
  ) u_result_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (back_res_valid),
    .data_i (back_res),
    .ready_o(out_ready),
    .pop_i  (pop),
    .valid_o(out_valid),
    .data_o (out_res)
  );

  assign empty           = !out_valid;
  assign amplitude_out_o = out_res.amp;
  assign frequency_out_o = out_res.freq;

endmodule

[src/sphd_checker.sv]
// ----------------------------------------------------------------------------
// Spectral peak hold checker
// Port-level checks of word accounting, reset clearing and result stalls.
// ----------------------------------------------------------------------------
module sphd_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              push,
  input logic                              full,
  input logic                              pop,
  input logic                              empty,
  input logic [sphd_pkg::AMP_W-1:0]        amplitude_out_o,
  input logic [sphd_pkg::FREQ_W-1:0]       frequency_out_o
);
  import sphd_pkg::*;

  // Front stage, item queue, back stage and result queue together.
  localparam logic [3:0] Capacity = 4'd6;

  logic [3:0] inflight_q, inflight_d;
  logic       in_acc, out_acc;

  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;

  always_comb begin
    inflight_d = inflight_q;
    if (in_acc && !out_acc) begin
      inflight_d = inflight_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      inflight_d = inflight_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // The store is swept right after reset, so no word is taken then.
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> full)
    else $error("input accepted while the store is being cleared");

  // A result never shows up without a word that caused it.
  a_no_invented_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (inflight_q != 4'd0))
    else $error("result shown with no word in flight");

  // The pipeline holds a bounded number of words.
  a_bounded_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inflight_q >= Capacity) |-> full)
    else $error("input accepted beyond pipeline capacity");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(amplitude_out_o) && $stable(frequency_out_o)))
    else $error("stalled result changed or vanished");

endmodule

bind spectral_peak_hold_decay sphd_checker u_sphd_checker (.*);
